### rtl/multipath_increase_correction_assert.svh
// assertion macros for the multipath increase correction block
// no dependencies; users need signals clk and rst_n in scope
`ifndef MULTIPATH_INCREASE_CORRECTION_ASSERT_SVH
`define MULTIPATH_INCREASE_CORRECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that holds at every edge out of reset
`define MIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequence that holds in the cycle after the antecedent
`define MIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MIC_ASSERT(lbl, prop, msg)
`define MIC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/mic_pkg.sv
// shared types and constants of the multipath increase correction block
// no dependencies
`default_nettype none
package mic_pkg;
  localparam int MAX_PATHS_DEF = 8;
  localparam int DIV_DW = 49;
  localparam int DIV_SW = 32;

  localparam logic [1:0] MODE_HOP   = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_EVAL  = 2'd2;

  localparam logic [1:0] ST_UPDATED    = 2'd0;
  localparam logic [1:0] ST_NO_FEEDBACK = 2'd1;
  localparam logic [1:0] ST_FEW_PATHS  = 2'd2;
  localparam logic [1:0] ST_NO_CURRENT = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [47:0] win;
    logic [31:0] rate;
    logic [31:0] cost;
    logic [31:0] rtt;
  } path_entry_t;
endpackage
`default_nettype wire

### rtl/multipath_increase_correction.sv
// Multipath increase correction: one item per start pulse, busy high while it
// is worked. A hop item with a nonzero rate and a recorded path close both
// wait on the 49-step shared divider; a skipped or dropped close and a
// zero-rate hop never start it. An evaluate item that fails its checks is
// answered from idle; otherwise it scans every stored path and divides out
// a correction when one is needed. Only an evaluate gives a result, a single
// one, for exactly one cycle with out_valid; the receiver cannot stall it.
// depends on mic_pkg, mic_div, mic_ram and the assertion header
`default_nettype none
`include "multipath_increase_correction_assert.svh"
module multipath_increase_correction import mic_pkg::*; #(
  parameter int MAX_PATHS = MAX_PATHS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_fair_rate,
  input  wire logic [31:0] in_cwnd_bytes,
  input  wire logic [15:0] in_seg_size,
  input  wire logic [31:0] in_rtt_us,
  input  wire logic        in_is_current,
  input  wire logic [31:0] in_additive_increase,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_new_increase,
  output logic             out_best_flag,
  output logic             out_max_window_flag,
  output logic signed [32:0] out_correction_q16,
  output logic [31:0]      out_path_cost,
  output logic [31:0]      out_bottleneck_rate
);
  localparam int IW = $clog2(MAX_PATHS);
  localparam int CW = $clog2(MAX_PATHS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HOP  = 4'd1;
  localparam logic [3:0] S_WIN  = 4'd2;
  localparam logic [3:0] S_MLO  = 4'd3;
  localparam logic [3:0] S_MHI  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_EA   = 4'd6;
  localparam logic [3:0] S_ED   = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;
  localparam logic [3:0] S_CORR = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]    state_r;
  logic [31:0]   hop_min_r;
  logic [55:0]   hop_inv_r;
  logic [7:0]    hop_cnt_r;
  logic          fb_bad_r;
  logic [CW-1:0] path_cnt_r;
  logic          cur_valid_r;
  logic [IW-1:0] cur_idx_r;
  logic [15:0]   cur_seg_r;
  logic [31:0]   best_rate_r, best_cost_r, best_rtt_r;
  logic [47:0]   max_win_r;
  logic [15:0]   seg_r;
  logic [31:0]   rtt_r;
  logic          is_cur_r;
  logic [31:0]   ai_r;
  logic [47:0]   win_r;
  logic [63:0]   prod_lo_r, prod_hi_r;
  logic [CW-1:0] scan_r, maxw_cnt_r, coll_cnt_r;
  path_entry_t   cap_r;
  logic          neg_r;
  logic [31:0]   mag_r;

  logic          accept;
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic [40:0]   cost_sum;
  logic [31:0]   cost;
  logic          beats;
  path_entry_t   new_ent;
  path_entry_t   ent;
  logic [$bits(path_entry_t)-1:0] ram_rdata;
  logic          ram_we;
  logic          ent_best, ent_max, cap_best, cap_max;
  logic [2*CW-1:0] den;
  logic [1:0]    ev_status;
  logic [56:0]   inv_sum;
  logic [47:0]   quo_win;
  logic signed [32:0] corr_s;
  logic signed [50:0] sum_s;
  logic [31:0]   new_ai;
  logic          clr_hops, clr_all;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;

  // shared divider
  mic_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // path table
  assign ram_we = state_r == S_WR;
  mic_ram #(.WIDTH($bits(path_entry_t)), .DEPTH(MAX_PATHS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(path_cnt_r[IW-1:0]), .wdata(new_ent),
    .raddr(scan_r[IW-1:0]), .rdata(ram_rdata)
  );
  assign ent = ram_rdata;

  // shared multiplier for the two cost partial products
  assign mul_b = (state_r == S_MLO) ? hop_inv_r[31:0] : {8'd0, hop_inv_r[55:32]};
  assign mul_p = hop_min_r * mul_b;

  // cost from the partial products, saturating
  assign cost_sum = 41'(prod_lo_r[63:24]) + 41'({prod_hi_r[23:0], 8'd0});
  always_comb begin
    if (prod_hi_r >= 64'h100_0000 || cost_sum[40:32] != 9'd0) begin
      cost = 32'hFFFF_FFFF;
    end else begin
      cost = cost_sum[31:0];
    end
  end

  assign new_ent.win  = win_r;
  assign new_ent.rate = hop_min_r;
  assign new_ent.cost = cost;
  assign new_ent.rtt  = rtt_r;

  // ranking of the new path against the best so far
  assign beats = (path_cnt_r == '0) || (hop_min_r > best_rate_r) ||
                 (hop_min_r == best_rate_r && cost < best_cost_r) ||
                 (hop_min_r == best_rate_r && cost == best_cost_r && rtt_r < best_rtt_r);

  // scan compares
  assign ent_best = ent.rate == best_rate_r && ent.cost == best_cost_r &&
                    ent.rtt == best_rtt_r;
  assign ent_max  = ent.win == max_win_r;
  assign cap_best = cap_r.rate == best_rate_r && cap_r.cost == best_cost_r &&
                    cap_r.rtt == best_rtt_r;
  assign cap_max  = cap_r.win == max_win_r;

  // evaluate status, in priority order
  always_comb begin
    if (fb_bad_r) begin
      ev_status = ST_NO_FEEDBACK;
    end else if (path_cnt_r <= CW'(1)) begin
      ev_status = ST_FEW_PATHS;
    end else if (!cur_valid_r) begin
      ev_status = ST_NO_CURRENT;
    end else begin
      ev_status = ST_UPDATED;
    end
  end

  // correction denominator
  assign den = (cap_best && !cap_max) ? path_cnt_r * coll_cnt_r
                                      : path_cnt_r * maxw_cnt_r;

  // divider requests
  always_comb begin
    div_req = '0;
    if (accept && in_mode == MODE_HOP && in_fair_rate != 32'd0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_DW'(49'h1_0000_0000_0000);
      div_req.divisor  = in_fair_rate;
    end else if (accept && in_mode == MODE_CLOSE && in_seg_size != 16'd0 &&
                 in_rtt_us != 32'd0 && path_cnt_r < CW'(MAX_PATHS)) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, in_cwnd_bytes, 16'd0};
      div_req.divisor  = {16'd0, in_seg_size};
    end else if (state_r == S_DEC && coll_cnt_r != '0 &&
                 ((cap_best && !cap_max) || cap_max)) begin
      div_req.start    = 1'b1;
      div_req.dividend = {17'd0, cur_seg_r, 16'd0};
      div_req.divisor  = {{(DIV_SW-2*CW){1'b0}}, den};
    end
  end

  // hop accumulation and window floor
  assign inv_sum = {1'b0, hop_inv_r} + 57'(div_rsp.quotient);
  assign quo_win = (div_rsp.quotient < 49'h1_0000) ? 48'h1_0000 : div_rsp.quotient[47:0];

  // final increase
  assign corr_s = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign sum_s  = $signed({3'd0, ai_r, 16'd0}) + 51'(corr_s);
  always_comb begin
    if (sum_s[50]) begin
      new_ai = 32'd0;
    end else if (sum_s[49:48] != 2'd0) begin
      new_ai = 32'hFFFF_FFFF;
    end else begin
      new_ai = sum_s[47:16];
    end
  end

  // connection state is kept until the result of an evaluate is out
  assign clr_all  = (accept && in_mode == MODE_EVAL && ev_status != ST_UPDATED) ||
                    state_r == S_FIN;
  assign clr_hops = (accept && in_mode == MODE_CLOSE &&
                     (in_seg_size == 16'd0 || in_rtt_us == 32'd0 ||
                      path_cnt_r >= CW'(MAX_PATHS))) || state_r == S_WR;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid   <= 1'b0;
      hop_min_r   <= '1;
      hop_inv_r   <= '0;
      hop_cnt_r   <= '0;
      fb_bad_r    <= 1'b0;
      path_cnt_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_idx_r   <= '0;
      cur_seg_r   <= '0;
      max_win_r   <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_HOP: begin
                if (in_fair_rate == 32'd0) begin
                  fb_bad_r <= 1'b1;
                end else begin
                  if (in_fair_rate < hop_min_r) begin
                    hop_min_r <= in_fair_rate;
                  end
                  state_r <= S_HOP;
                end
                if (hop_cnt_r != 8'hFF) begin
                  hop_cnt_r <= hop_cnt_r + 8'd1;
                end
              end
              MODE_CLOSE: begin
                if (in_seg_size != 16'd0 && in_rtt_us != 32'd0) begin
                  if (hop_cnt_r == 8'd0) begin
                    fb_bad_r <= 1'b1;
                  end
                  if (path_cnt_r < CW'(MAX_PATHS)) begin
                    seg_r    <= in_seg_size;
                    rtt_r    <= in_rtt_us;
                    is_cur_r <= in_is_current;
                    state_r  <= S_WIN;
                  end
                end
              end
              MODE_EVAL: begin
                ai_r <= in_additive_increase;
                if (ev_status != ST_UPDATED) begin
                  out_valid           <= 1'b1;
                  out_status          <= ev_status;
                  out_new_increase    <= in_additive_increase;
                  out_best_flag       <= 1'b0;
                  out_max_window_flag <= 1'b0;
                  out_correction_q16  <= '0;
                  out_path_cost       <= '0;
                  out_bottleneck_rate <= '0;
                end else begin
                  scan_r     <= '0;
                  maxw_cnt_r <= '0;
                  coll_cnt_r <= '0;
                  state_r    <= S_EA;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_HOP: begin
          if (div_rsp.done) begin
            hop_inv_r <= inv_sum[56] ? '1 : inv_sum[55:0];
            state_r   <= S_IDLE;
          end
        end
        S_WIN: begin
          if (div_rsp.done) begin
            win_r   <= quo_win;
            state_r <= S_MLO;
          end
        end
        S_MLO: begin
          prod_lo_r <= mul_p;
          state_r   <= S_MHI;
        end
        S_MHI: begin
          prod_hi_r <= mul_p;
          state_r   <= S_WR;
        end
        S_WR: begin
          if (beats) begin
            best_rate_r <= hop_min_r;
            best_cost_r <= cost;
            best_rtt_r  <= rtt_r;
          end
          if (win_r > max_win_r) begin
            max_win_r <= win_r;
          end
          if (is_cur_r) begin
            cur_valid_r <= 1'b1;
            cur_idx_r   <= path_cnt_r[IW-1:0];
            cur_seg_r   <= seg_r;
          end
          path_cnt_r <= path_cnt_r + CW'(1);
          state_r    <= S_IDLE;
        end
        S_EA: begin
          state_r <= S_ED;
        end
        S_ED: begin
          if (ent_max) begin
            maxw_cnt_r <= maxw_cnt_r + CW'(1);
          end
          if (ent_best && !ent_max) begin
            coll_cnt_r <= coll_cnt_r + CW'(1);
          end
          if (scan_r[IW-1:0] == cur_idx_r) begin
            cap_r <= ent;
          end
          scan_r  <= scan_r + CW'(1);
          state_r <= (scan_r + CW'(1) == path_cnt_r) ? S_DEC : S_EA;
        end
        S_DEC: begin
          neg_r <= cap_max;
          mag_r <= '0;
          state_r <= div_req.start ? S_CORR : S_FIN;
        end
        S_CORR: begin
          if (div_rsp.done) begin
            mag_r   <= div_rsp.quotient[31:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid           <= 1'b1;
          out_status          <= ST_UPDATED;
          out_new_increase    <= new_ai;
          out_best_flag       <= cap_best;
          out_max_window_flag <= cap_max;
          out_correction_q16  <= corr_s;
          out_path_cost       <= cap_r.cost;
          out_bottleneck_rate <= cap_r.rate;
          state_r             <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // hop accumulators back to reset after a close or an evaluate
      if (clr_hops || clr_all) begin
        hop_min_r <= '1;
        hop_inv_r <= '0;
        hop_cnt_r <= '0;
      end
      // whole connection state back to reset after an evaluate
      if (clr_all) begin
        fb_bad_r    <= 1'b0;
        path_cnt_r  <= '0;
        cur_valid_r <= 1'b0;
        cur_idx_r   <= '0;
        cur_seg_r   <= '0;
        max_win_r   <= '0;
      end
    end
  end

  `MIC_ASSERT(a_path_bound, path_cnt_r <= CW'(MAX_PATHS), "path count beyond table")
  `MIC_ASSERT(a_emit_idle, out_valid |-> !busy, "result shown while busy")
  `MIC_ASSERT(a_cleared_after_emit, out_valid |-> (path_cnt_r == '0 && !cur_valid_r && !fb_bad_r), "state not cleared after evaluate")
  `MIC_ASSERT(a_zero_on_fail, (out_valid && out_status != ST_UPDATED) |-> (out_correction_q16 == '0 && out_path_cost == '0 && !out_best_flag), "failed evaluate carries data")
endmodule
`default_nettype wire

### rtl/mic_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module mic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mic_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on mic_pkg and the assertion header
`default_nettype none
`include "multipath_increase_correction_assert.svh"
module mic_div import mic_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);
  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [DIV_DW-1:0] q_r;
  logic [DIV_SW-1:0] rem_r;
  logic [DIV_SW-1:0] dvs_r;
  logic [DIV_SW:0]   trial;
  logic              fits;

  // trial subtraction of one step
  assign trial = {rem_r, q_r[DIV_DW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_DW);
        q_r    <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_SW'(trial - {1'b0, dvs_r}) : trial[DIV_SW-1:0];
        q_r   <= {q_r[DIV_DW-2:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  `MIC_ASSERT(a_rem_below_divisor, busy_r |-> rem_r < dvs_r, "remainder out of range")
  `MIC_ASSERT_NEXT(a_done_single, done_r, !done_r, "done held longer than one cycle")
  `MIC_ASSERT(a_no_restart, req.start |-> !busy_r, "divider started while busy")
endmodule
`default_nettype wire
